/* hdl/assert_macros.svh */
// Assertion macros used by the checker module of the tile encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication checked outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold on every cycle outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

/* hdl/tne_pkg.sv */
// Types and constants of the tile neighbor autotile encoder.
package tne_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  localparam logic [7:0] RST_MAP_WIDTH  = 8'd98;
  localparam logic [7:0] RST_MAP_HEIGHT = 8'd66;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'd1;

  localparam logic [2:0] KIND_GRASS = 3'd0;
  localparam logic [2:0] KIND_TREE  = 3'd1;
  localparam logic [2:0] KIND_DIRT  = 3'd2;
  localparam logic [2:0] KIND_WALL  = 3'd3;
  localparam logic [2:0] KIND_DWALL = 3'd4;
  localparam logic [2:0] KIND_ROCK  = 3'd5;
  localparam logic [2:0] KIND_WATER = 3'd6;

  localparam logic [2:0] CLS_GRASS  = 3'd0;
  localparam logic [2:0] CLS_TRANS  = 3'd1;
  localparam logic [2:0] CLS_WATER  = 3'd2;
  localparam logic [2:0] CLS_ROCK   = 3'd3;
  localparam logic [2:0] CLS_TREE   = 3'd4;
  localparam logic [2:0] CLS_WALL   = 3'd5;
  localparam logic [2:0] CLS_DIRT   = 3'd6;
  localparam logic [2:0] CLS_DWALL  = 3'd7;

  typedef struct packed {
    logic [2:0] tile_kind;
    logic       start_of_map;
  } in_item_t;

  typedef struct packed {
    logic [6:0] center_row;
    logic [6:0] center_col;
    logic [2:0] image_class;
    logic [7:0] image_index;
    logic       tree_top_valid;
    logic [5:0] tree_top_index;
  } out_item_t;

endpackage

/* hdl/tile_neighbor_autotile_encoder.sv */
// Top level of the tile neighbor autotile encoder.
// Tiles enter on the in_ channel in raster order, border rows and columns
// included, one tile per transfer; start_of_map marks the first tile of a map.
// For every interior tile one result leaves on the out_ channel once the tile
// below and right of it has arrived: it carries the tile position, the image
// class and the neighbor bitmask.  Border tiles give no result.
// The block takes one tile per cycle while in_stall is low.  A tile's line
// buffer entry is read from a single memory at transfer time and written back
// when the tile leaves the working stage, with the entry forwarded when the next
// tile reads the same column.  out_valid is registered and rises when the tile
// that completes a window leaves the working stage.
// The output register lets a new tile enter while a result waits to be taken;
// when out_stall holds and both the output and the working stage are full,
// in_stall rises until the receiver takes the result.
// map_width and map_height must be written on the cfg_ port only while the block
// is idle, which the block itself does not enforce; values outside 3 to the
// maximum are clamped.  Reset clears the row and column counters and the window
// and sets the sizes to 98 by 66; the line memory needs no clearing pass.
module tile_neighbor_autotile_encoder
  import tne_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CWW = (WW > 8) ? WW : 8;
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int HWW = (HW > 8) ? HW : 8;
  localparam int OW  = (HW > 7) ? HW : 7;
  localparam int OC  = (WW > 7) ? WW : 7;

  // Configuration registers.
  logic [7:0] width_cfg_r, height_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= RST_MAP_WIDTH;
      height_cfg_r <= RST_MAP_HEIGHT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  width_cfg_r  <= cfg_wdata;
        REG_MAP_HEIGHT: height_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CWW-1:0] w_ext, w_cl;
  logic [HWW-1:0] h_ext, h_cl;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;

  always_comb begin
    w_ext = CWW'(width_cfg_r);
    h_ext = HWW'(height_cfg_r);
    if (w_ext < CWW'(3))              w_cl = CWW'(3);
    else if (w_ext > CWW'(MAX_WIDTH)) w_cl = CWW'(MAX_WIDTH);
    else                              w_cl = w_ext;
    if (h_ext < HWW'(3))               h_cl = HWW'(3);
    else if (h_ext > HWW'(MAX_HEIGHT)) h_cl = HWW'(MAX_HEIGHT);
    else                               h_cl = h_ext;
    w_eff = w_cl[WW-1:0];
    h_eff = h_cl[HW-1:0];
  end

  // Handshake and stage control.
  logic s1_valid_r, out_valid_r, adv1, in_acc;

  assign adv1     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv1;
  assign in_acc   = in_valid && !in_stall;

  // Raster counters, evaluated for the incoming tile.
  logic [CW-1:0] col_r, col_cur, col_nxt;
  logic [RW-1:0] row_r, row_cur, row_nxt;
  logic [WW-1:0] col_x, col_x1;
  logic [HW-1:0] row_x, row_x1;

  always_comb begin
    col_cur = col_r;
    row_cur = row_r;
    if (in_data.start_of_map) begin
      col_cur = '0;
      row_cur = '0;
    end
    if (WW'(col_cur) >= w_eff) col_cur = '0;
    if (HW'(row_cur) >= h_eff) row_cur = '0;
    col_x  = WW'(col_cur);
    row_x  = HW'(row_cur);
    col_x1 = col_x + WW'(1);
    row_x1 = row_x + HW'(1);
    if (col_x1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_x1 >= h_eff) ? '0 : row_x1[RW-1:0];
    end else begin
      col_nxt = col_x1[CW-1:0];
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Working stage: one tile whose line memory entry has been read.
  logic [2:0]    s1_kind_r;
  logic [CW-1:0] s1_col_r;
  logic [OW-1:0] s1_cr_r;
  logic [OC-1:0] s1_cc_r;
  logic          s1_emit_r, s1_top_r, s1_bot_r, s1_lft_r, s1_rgt_r, s1_tall_r;
  logic          fwd_r;
  logic [5:0]    fwd_data_r, mem_q_r, eff;
  logic [2:0]    eff_a, eff_b;

  // Each entry holds the kinds of the two previous rows at that column.
  logic [5:0] line_mem [MAX_WIDTH];

  assign eff   = fwd_r ? fwd_data_r : mem_q_r;
  assign eff_a = eff[5:3];
  assign eff_b = eff[2:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_q_r <= line_mem[col_cur];
    end
    if (adv1) begin
      line_mem[s1_col_r] <= {eff_b, s1_kind_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
      // The tile leaving the stage writes the entry that this one reads.
      fwd_r      <= s1_valid_r && (col_cur == s1_col_r);
    end else if (adv1) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_data_r <= {eff_b, s1_kind_r};
      s1_kind_r  <= in_data.tile_kind;
      s1_col_r   <= col_cur;
      s1_cr_r    <= OW'(row_x) - OW'(1);
      s1_cc_r    <= OC'(col_x) - OC'(1);
      s1_emit_r  <= (row_x >= HW'(2)) && (col_x >= WW'(2));
      s1_top_r   <= (row_x == HW'(2));
      s1_bot_r   <= (row_x1 == h_eff);
      s1_lft_r   <= (col_x == WW'(2));
      s1_rgt_r   <= (col_x1 == w_eff);
      s1_tall_r  <= (row_x >= HW'(3));
    end
  end

  // 3x3 window, index row*3+col with the newest column at col 2.
  logic [2:0] win_r   [9];
  logic [2:0] win_nxt [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]     = win_r[i*3+1];
      win_nxt[i*3+1]   = win_r[i*3+2];
    end
    win_nxt[2] = eff_a;
    win_nxt[5] = eff_b;
    win_nxt[8] = s1_kind_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (adv1) begin
      for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
    end
  end

  // Neighbor kinds; bit 3 set marks a border neighbor that never matches.
  logic [3:0] nb_dr, nb_bl, nb_dl, nb_rt, nb_lf, nb_ur, nb_up, nb_ul, ctr;
  logic [3:0] nb [8];
  logic [7:0] m_same, m_diff;
  logic [2:0] cls;
  logic [7:0] idx;
  logic       tv;
  logic [5:0] ti;

  assign ctr   = {1'b0, win_nxt[4]};
  assign nb_dr = (s1_bot_r || s1_rgt_r) ? 4'h8 : {1'b0, win_nxt[8]};
  assign nb_bl = s1_bot_r               ? 4'h8 : {1'b0, win_nxt[7]};
  assign nb_dl = (s1_bot_r || s1_lft_r) ? 4'h8 : {1'b0, win_nxt[6]};
  assign nb_rt = s1_rgt_r               ? 4'h8 : {1'b0, win_nxt[5]};
  assign nb_lf = s1_lft_r               ? 4'h8 : {1'b0, win_nxt[3]};
  assign nb_ur = (s1_top_r || s1_rgt_r) ? 4'h8 : {1'b0, win_nxt[2]};
  assign nb_up = s1_top_r               ? 4'h8 : {1'b0, win_nxt[1]};
  assign nb_ul = (s1_top_r || s1_lft_r) ? 4'h8 : {1'b0, win_nxt[0]};

  always_comb begin
    nb[7] = nb_dr; nb[6] = nb_bl; nb[5] = nb_dl; nb[4] = nb_rt;
    nb[3] = nb_lf; nb[2] = nb_ur; nb[1] = nb_up; nb[0] = nb_ul;
    for (int i = 0; i < 8; i++) begin
      m_same[i] = (nb[i] == ctr);
      m_diff[i] = (nb[i] != {1'b0, KIND_GRASS}) && (nb[i] != {1'b0, KIND_WALL}) &&
                  (nb[i] != {1'b0, KIND_TREE});
    end
    cls = CLS_DIRT;
    idx = '0;
    tv  = 1'b0;
    ti  = '0;
    case (win_nxt[4]) inside
      KIND_WATER, KIND_ROCK: begin
        cls = (win_nxt[4] == KIND_WATER) ? CLS_WATER : CLS_ROCK;
        idx = m_same;
      end
      KIND_GRASS: begin
        cls = (m_diff == '0) ? CLS_GRASS : CLS_TRANS;
        idx = m_diff;
      end
      KIND_TREE: begin
        cls = CLS_TREE;
        idx = {2'b00, m_same[7], m_same[6], m_same[5], m_same[4], 1'b1, m_same[3]};
        if (!m_same[1] && s1_tall_r) begin
          tv = 1'b1;
          ti = {m_same[4], 1'b1, m_same[3], m_same[2], m_same[1], m_same[0]};
        end
      end
      KIND_WALL: begin
        cls = CLS_WALL;
        idx = {4'b0000, m_same[3], m_same[6], m_same[4], m_same[1]};
      end
      KIND_DWALL: cls = CLS_DWALL;
      default:    cls = CLS_DIRT;
    endcase
  end

  // Output register.
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv1 && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s1_emit_r) begin
      out_data_r.center_row     <= s1_cr_r[6:0];
      out_data_r.center_col     <= s1_cc_r[6:0];
      out_data_r.image_class    <= cls;
      out_data_r.image_index    <= idx;
      out_data_r.tree_top_valid <= tv;
      out_data_r.tree_top_index <= ti;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/tne_checker.sv */
// Port-level checker for the tile neighbor autotile encoder, bound to the top level.
`include "assert_macros.svh"

module tne_checker
  import tne_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_CLK(a_tree_center, clk, rst_n, out_valid && out_data.image_class == CLS_TREE |-> out_data.image_index[1] && out_data.image_index[7:6] == 2'b00, "tree mask malformed")
  `ASSERT_CLK(a_top_class, clk, rst_n, out_valid && out_data.tree_top_valid |-> out_data.image_class == CLS_TREE && out_data.tree_top_index[4], "tree top on a non-tree tile")
  `ASSERT_ALWAYS(a_top_zero, clk, rst_n, !out_valid || out_data.tree_top_valid || out_data.tree_top_index == 6'd0, "tree top index set without tree top")
  `ASSERT_CLK(a_grass_plain, clk, rst_n, out_valid && out_data.image_class == CLS_GRASS |-> out_data.image_index == 8'd0, "plain grass with a nonzero mask")

endmodule

bind tile_neighbor_autotile_encoder tne_checker u_tne_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/tb.sv */
// Self-checking testbench for the tile neighbor autotile encoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tne_pkg::*;

  localparam logic [2:0] KIND_SPARE = 3'd7;
  localparam logic [3:0] OFF_MAP = 4'd8;
  localparam int LINE_DEPTH = DEF_MAX_WIDTH;
  localparam int TILE_BUDGET = 1400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 4000;
  localparam int CYCLE_LIMIT = 800000;
  localparam out_item_t NO_CODE = '0;

  typedef struct packed {
    logic [2:0] kind;
    logic       start;
    logic       typed;
    out_item_t  code;
  } strip_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAP_WIDTH;
  logic [7:0] cfg_wdata = '0;

  // Shadow of the encoder: sizes, the two stored rows, the 3x3 view, position.
  logic [7:0] map_w = RST_MAP_WIDTH;
  logic [7:0] map_h = RST_MAP_HEIGHT;
  logic [2:0] older_row [LINE_DEPTH];
  logic [2:0] last_row [LINE_DEPTH];
  logic [2:0] view [9];
  int row_ctr = 0;
  int col_ctr = 0;

  out_item_t codes_due [$];
  out_item_t code_now;
  strip_row_t strip [27];
  logic [2:0] palette [3];
  bit calm = 1'b0;
  int stall_left = 0;
  int faults = 0;
  int tiles_sent = 0;
  int codes_seen = 0;
  int settings_used = 0;
  int cycles = 0;

  tile_neighbor_autotile_encoder uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int clamp_dim(logic [7:0] v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [2:0] pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return palette[0];
    if (r < 7) return palette[1];
    if (r < 9) return palette[2];
    return 3'($urandom_range(0, 7));
  endfunction

  // Neighbor kind in the view, or OFF_MAP when it sits on the map border.
  function automatic logic [3:0] around(int rr, int cc, int cr, int ccol, int w, int h);
    if (rr == 0 && cr == 1) return OFF_MAP;
    if (rr == 2 && cr + 1 == h - 1) return OFF_MAP;
    if (cc == 0 && ccol == 1) return OFF_MAP;
    if (cc == 2 && ccol + 1 == w - 1) return OFF_MAP;
    return {1'b0, view[rr * 3 + cc]};
  endfunction

  task automatic encode_tile(input in_item_t t, output bit has_code, output out_item_t code);
    int w, h, row, col, cr, cc, i;
    logic [3:0] ctr, dr, bl, dl, rt, lf, ur, up, ul;
    logic [3:0] nb [8];
    logic [7:0] m;
    w = clamp_dim(map_w, DEF_MAX_WIDTH);
    h = clamp_dim(map_h, DEF_MAX_HEIGHT);
    if (t.start_of_map) begin
      row_ctr = 0;
      col_ctr = 0;
    end
    if (col_ctr >= w) col_ctr = 0;
    if (row_ctr >= h) row_ctr = 0;
    row = row_ctr;
    col = col_ctr;
    for (i = 0; i < 3; i++) begin
      view[i * 3] = view[i * 3 + 1];
      view[i * 3 + 1] = view[i * 3 + 2];
    end
    view[2] = older_row[col];
    view[5] = last_row[col];
    view[8] = t.tile_kind;
    older_row[col] = last_row[col];
    last_row[col] = t.tile_kind;
    has_code = 1'b0;
    code = NO_CODE;
    if (row >= 2 && col >= 2) begin
      cr = row - 1;
      cc = col - 1;
      ctr = {1'b0, view[4]};
      dr = around(2, 2, cr, cc, w, h);
      bl = around(2, 1, cr, cc, w, h);
      dl = around(2, 0, cr, cc, w, h);
      rt = around(1, 2, cr, cc, w, h);
      lf = around(1, 0, cr, cc, w, h);
      ur = around(0, 2, cr, cc, w, h);
      up = around(0, 1, cr, cc, w, h);
      ul = around(0, 0, cr, cc, w, h);
      nb[0] = dr; nb[1] = bl; nb[2] = dl; nb[3] = rt;
      nb[4] = lf; nb[5] = ur; nb[6] = up; nb[7] = ul;
      m = '0;
      has_code = 1'b1;
      code.center_row = 7'(cr);
      code.center_col = 7'(cc);
      case (view[4])
        KIND_WATER, KIND_ROCK: begin
          for (i = 0; i < 8; i++) m = {m[6:0], nb[i] == ctr};
          code.image_class = (view[4] == KIND_WATER) ? CLS_WATER : CLS_ROCK;
          code.image_index = m;
        end
        KIND_GRASS: begin
          // Grass flags every neighbor that would need a dirt edge drawn.
          for (i = 0; i < 8; i++) begin
            m = {m[6:0], !(nb[i] == KIND_GRASS || nb[i] == KIND_WALL || nb[i] == KIND_TREE)};
          end
          code.image_class = (m == 0) ? CLS_GRASS : CLS_TRANS;
          code.image_index = m;
        end
        KIND_TREE: begin
          code.image_class = CLS_TREE;
          code.image_index = {2'b00, dr == ctr, bl == ctr, dl == ctr, rt == ctr, 1'b1, lf == ctr};
          if (up != ctr && cr >= 2) begin
            code.tree_top_valid = 1'b1;
            code.tree_top_index = {rt == ctr, 1'b1, lf == ctr, ur == ctr, up == ctr, ul == ctr};
          end
        end
        KIND_WALL: begin
          code.image_class = CLS_WALL;
          code.image_index = {4'b0000, lf == ctr, bl == ctr, rt == ctr, up == ctr};
        end
        KIND_DWALL: code.image_class = CLS_DWALL;
        default: code.image_class = CLS_DIRT;
      endcase
    end
    if (col + 1 >= w) begin
      col_ctr = 0;
      row_ctr = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_ctr = col + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      faults++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Result side: check every transfer against the oldest code due.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      if (codes_due.size() == 0) begin
        faults++;
        $error("tile code for row %0d col %0d arrived with none due",
               out_data.center_row, out_data.center_col);
      end else begin
        code_now = codes_due.pop_front();
        check_field("center_row", 8'(code_now.center_row), 8'(out_data.center_row));
        check_field("center_col", 8'(code_now.center_col), 8'(out_data.center_col));
        check_field("image_class", 8'(code_now.image_class), 8'(out_data.image_class));
        check_field("image_index", code_now.image_index, out_data.image_index);
        check_field("tree_top_valid", 8'(code_now.tree_top_valid),
                    8'(out_data.tree_top_valid));
        check_field("tree_top_index", 8'(code_now.tree_top_index),
                    8'(out_data.tree_top_index));
        codes_seen++;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_tile(input in_item_t t, input logic typed, input out_item_t typed_code);
    int gap;
    bit has_code;
    out_item_t code;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    encode_tile(t, has_code, code);
    if (has_code) codes_due.push_back(typed ? typed_code : code);
    tiles_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (codes_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (codes_due.size() != 0) begin
      faults++;
      $error("%0d tile codes never arrived", codes_due.size());
      codes_due.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_MAP_WIDTH) map_w = val;
    else map_h = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_sizes(input logic [7:0] wv, input logic [7:0] hv);
    settle();
    write_reg(REG_MAP_WIDTH, wv);
    write_reg(REG_MAP_HEIGHT, hv);
    settings_used++;
  endtask

  task automatic new_palette();
    int i;
    for (i = 0; i < 3; i++) palette[i] = 3'($urandom_range(0, 7));
  endtask

  // Raster tiles; now and then a stray start of map restarts the count.
  task automatic stream_tiles(input int count, input bit lead_start);
    in_item_t t;
    int k;
    for (k = 0; k < count; k++) begin
      t.tile_kind = pick_kind();
      t.start_of_map = (k == 0 && lead_start) || ($urandom_range(0, 299) == 0);
      push_tile(t, 1'b0, NO_CODE);
    end
  endtask

  task automatic run_phase(input logic [7:0] wv, input logic [7:0] hv);
    int w, h, nmaps, len, m;
    bit cut;
    set_sizes(wv, hv);
    calm = ($urandom_range(0, 4) == 0);
    w = clamp_dim(wv, DEF_MAX_WIDTH);
    h = clamp_dim(hv, DEF_MAX_HEIGHT);
    // Large maps run once so the tile count stays near the budget.
    nmaps = (w * h > 200) ? 1 : $urandom_range(1, 3);
    cut = 1'b1;
    for (m = 0; m < nmaps; m++) begin
      new_palette();
      len = w * h;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
      stream_tiles(len, cut || $urandom_range(0, 3) != 0);
      cut = (len < w * h);
    end
    if ($urandom_range(0, 3) == 0) begin
      // Resize partway through a map. The width never grows here, so every
      // column the next rows read has been written by an earlier row.
      stream_tiles($urandom_range(1, w * h - 1), 1'b1);
      settle();
      write_reg(REG_MAP_WIDTH, 8'($urandom_range(0, w)));
      write_reg(REG_MAP_HEIGHT, 8'($urandom_range(0, 12)));
      settings_used++;
      w = clamp_dim(map_w, DEF_MAX_WIDTH);
      h = clamp_dim(map_h, DEF_MAX_HEIGHT);
      len = (2 * w * h < 150) ? 2 * w * h : 150;
      stream_tiles($urandom_range(1, len), 1'b0);
    end
  endtask

  initial begin
    in_item_t t;
    int i;
    for (i = 0; i < LINE_DEPTH; i++) begin
      older_row[i] = '0;
      last_row[i] = '0;
    end
    for (i = 0; i < 9; i++) view[i] = '0;

    // A three-wide strip: only the tiles above and below can match, and the
    // border columns of several rows hold kinds that would match if they counted.
    strip = '{
      '{KIND_WATER, 1'b1, 1'b0, NO_CODE},
      '{KIND_WATER, 1'b0, 1'b0, NO_CODE},
      '{KIND_WATER, 1'b0, 1'b0, NO_CODE},
      '{KIND_TREE,  1'b0, 1'b0, NO_CODE},
      '{KIND_GRASS, 1'b0, 1'b0, NO_CODE},
      '{KIND_TREE,  1'b0, 1'b0, NO_CODE},
      '{KIND_WATER, 1'b0, 1'b0, NO_CODE},
      '{KIND_TREE,  1'b0, 1'b0, NO_CODE},
      '{KIND_WATER, 1'b0, 1'b1, '{7'd1, 7'd1, CLS_TRANS, 8'hBF, 1'b0, 6'd0}},
      '{KIND_TREE,  1'b0, 1'b0, NO_CODE},
      '{KIND_TREE,  1'b0, 1'b0, NO_CODE},
      '{KIND_TREE,  1'b0, 1'b1, '{7'd2, 7'd1, CLS_TREE, 8'd18, 1'b1, 6'd16}},
      '{KIND_WALL,  1'b0, 1'b0, NO_CODE},
      '{KIND_WALL,  1'b0, 1'b0, NO_CODE},
      '{KIND_WALL,  1'b0, 1'b1, '{7'd3, 7'd1, CLS_TREE, 8'd2, 1'b0, 6'd0}},
      '{KIND_WATER, 1'b0, 1'b0, NO_CODE},
      '{KIND_WATER, 1'b0, 1'b0, NO_CODE},
      '{KIND_WATER, 1'b0, 1'b1, '{7'd4, 7'd1, CLS_WALL, 8'h00, 1'b0, 6'd0}},
      '{KIND_ROCK,  1'b0, 1'b0, NO_CODE},
      '{KIND_WATER, 1'b0, 1'b0, NO_CODE},
      '{KIND_ROCK,  1'b0, 1'b1, '{7'd5, 7'd1, CLS_WATER, 8'h40, 1'b0, 6'd0}},
      '{KIND_SPARE, 1'b0, 1'b0, NO_CODE},
      '{KIND_SPARE, 1'b0, 1'b0, NO_CODE},
      '{KIND_SPARE, 1'b0, 1'b1, '{7'd6, 7'd1, CLS_WATER, 8'h02, 1'b0, 6'd0}},
      '{KIND_SPARE, 1'b0, 1'b0, NO_CODE},
      '{KIND_SPARE, 1'b0, 1'b0, NO_CODE},
      '{KIND_SPARE, 1'b0, 1'b1, '{7'd7, 7'd1, CLS_DIRT, 8'h00, 1'b0, 6'd0}}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sizes straight out of reset: three rows of a 98-wide map.
    new_palette();
    stream_tiles(3 * RST_MAP_WIDTH, 1'b1);

    set_sizes(8'd3, 8'd9);
    for (i = 0; i < 27; i++) begin
      t.tile_kind = strip[i].kind;
      t.start_of_map = strip[i].start;
      push_tile(t, strip[i].typed, strip[i].code);
    end

    run_phase(8'd255, 8'd0);
    run_phase(8'd0, 8'd255);
    run_phase(8'd1, 8'd2);
    while (tiles_sent < TILE_BUDGET) begin
      if ($urandom_range(0, 24) == 0) begin
        run_phase(8'($urandom_range(128, 255)), 8'($urandom_range(0, 3)));
      end else if ($urandom_range(0, 24) == 0) begin
        run_phase(8'($urandom_range(0, 3)), 8'($urandom_range(40, 80)));
      end else begin
        run_phase(8'($urandom_range(0, 12)), 8'($urandom_range(0, 10)));
      end
    end
    settle();

    $display("Sent %0d tiles over %0d size settings and checked %0d tile codes.",
             tiles_sent, settings_used, codes_seen);
    $display("Maps ran from 3x3 to full width and height, with restarts and resizes mid-map.");
    if (faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tne_pkg.sv
hdl/tile_neighbor_autotile_encoder.sv
hdl/tne_checker.sv
bench/tb.sv
